@@ sv/sal_pkg.sv @@
`default_nettype none

package sal_pkg;

   localparam int DataWidth = 32;
   localparam int DivBitsPerStage = 2;
   localparam int DivStages = DataWidth / DivBitsPerStage;

   typedef logic signed [DataWidth-1:0] word_type;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_DIV  = 4'd2,
      OP_MUL  = 4'd3,
      OP_MOD  = 4'd4,
      OP_NEG  = 4'd5,
      OP_LT   = 4'd6,
      OP_LE   = 4'd7,
      OP_GT   = 4'd8,
      OP_GE   = 4'd9,
      OP_BOOL = 4'd10,
      OP_ABS  = 4'd11,
      OP_MAX  = 4'd12,
      OP_MIN  = 4'd13,
      OP_SIGN = 4'd14
   } op_type;

   // Which value the last stage picks for the result.
   typedef enum logic [1:0] {
      SEL_DIRECT   = 2'd0,
      SEL_QUOTIENT = 2'd1,
      SEL_REMAIN   = 2'd2
   } sel_type;

   // Everything that travels down the pipeline with one item.
   typedef struct packed {
      logic [DataWidth-1:0] direct;    // result of the operations that need no divider
      sel_type              sel;
      logic                 negate;    // negate the quotient or remainder
      logic                 pops;
      logic                 div_zero;
      logic [DataWidth-1:0] remain;    // partial remainder
      logic [DataWidth-1:0] shift_q;   // dividend bits shift out, quotient bits shift in
      logic [DataWidth-1:0] divisor;   // divisor magnitude
   } item_type;

   // Two's complement magnitude; the minimum integer maps to 2^31 unsigned.
   function automatic logic [DataWidth-1:0] magnitude(input logic [DataWidth-1:0] v);
      magnitude = v[DataWidth-1] ? (~v + 1'b1) : v;
   endfunction

   // One restoring division step.
   function automatic item_type div_step(input item_type it);
      logic [DataWidth:0] trial;
      item_type           nx;
      nx = it;
      trial = {it.remain, it.shift_q[DataWidth-1]} - {1'b0, it.divisor};
      if (!trial[DataWidth]) begin
         nx.remain = trial[DataWidth-1:0];
      end else begin
         nx.remain = {it.remain[DataWidth-2:0], it.shift_q[DataWidth-1]};
      end
      nx.shift_q = {it.shift_q[DataWidth-2:0], ~trial[DataWidth]};
      div_step = nx;
   endfunction

endpackage

`default_nettype wire

@@ sv/sal_req_if.sv @@
`default_nettype none

interface sal_req_if;
   logic                  valid;
   logic                  ready;
   logic [3:0]            operation;
   logic signed [31:0]    second_value;
   logic signed [31:0]    top_value;

   modport source (output valid, output operation, output second_value,
                   output top_value, input ready);
   modport sink   (input valid, input operation, input second_value,
                   input top_value, output ready);
endinterface

`default_nettype wire

@@ sv/sal_rsp_if.sv @@
`default_nettype none

interface sal_rsp_if;
   logic                  valid;
   logic                  ready;
   logic signed [31:0]    result_value;
   logic                  pops_one;
   logic                  divide_by_zero;

   modport source (output valid, output result_value, output pops_one,
                   output divide_by_zero, input ready);
   modport sink   (input valid, input result_value, input pops_one,
                   input divide_by_zero, output ready);
endinterface

`default_nettype wire

@@ sv/stack_integer_alu.sv @@
`default_nettype none

// Channel   Direction  Contents
// req_ch    in         operation, second_value, top_value
// rsp_ch    out        result_value, pops_one, divide_by_zero
//
// Every item passes through 18 register stages: one decode stage that also
// finishes the multiply and all other non-divider operations, sixteen divider
// stages that each retire two quotient bits, and the output register.
// A new item can enter on every clock unless every stage is full and the
// output stalls. Each stage has a valid bit and loads when empty or when its
// successor moves, so bubbles close up; synchronous reset clears the valid bits.

module stack_integer_alu (
   input  wire logic   clock,
   input  wire logic   reset,
   sal_req_if.sink     req_ch,
   sal_rsp_if.source   rsp_ch
);
   import sal_pkg::*;

   // Stage links: index 0 is the decode stage output, index k the output
   // of divider stage k.
   item_type link_item  [DivStages+1];
   logic     link_valid [DivStages+1];
   logic     link_ready [DivStages+1];

   sal_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .out_item  (link_item[0]),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0])
   );

   // The divider is a chain of identical restoring stages. All items ride
   // through it; only division and modulo use what it computes.
   for (genvar k = 0; k < DivStages; k++) begin : g_div
      sal_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_item   (link_item[k]),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .out_item  (link_item[k+1]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1])
      );
   end

   // The last stage fixes the sign of the quotient or remainder and selects
   // the result that goes out.
   sal_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_item  (link_item[DivStages]),
      .in_valid (link_valid[DivStages]),
      .in_ready (link_ready[DivStages]),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

@@ sv/sal_front.sv @@
`default_nettype none

module sal_front (
   input  wire logic              clock,
   input  wire logic              reset,
   sal_req_if.sink                req_ch,
   output sal_pkg::item_type      out_item,
   output logic                   out_valid,
   input  wire logic              out_ready
);
   import sal_pkg::*;

   logic                  valid_ff;
   item_type              item_ff;
   item_type              item_in;
   logic [DataWidth-1:0]  a;
   logic [DataWidth-1:0]  b;
   logic                  a_lt_b;
   logic                  b_lt_a;
   logic [DataWidth-1:0]  product;

   assign req_ch.ready = !valid_ff || out_ready;
   assign a = req_ch.second_value;
   assign b = req_ch.top_value;
   assign a_lt_b = $signed(a) < $signed(b);
   assign b_lt_a = $signed(b) < $signed(a);
   assign product = a * b;

   always_comb begin
      item_in          = '0;
      item_in.sel      = SEL_DIRECT;
      item_in.remain   = '0;
      item_in.shift_q  = magnitude(a);
      item_in.divisor  = magnitude(b);
      case (op_type'(req_ch.operation))
         OP_ADD: begin
            item_in.direct = a + b;
            item_in.pops   = 1'b1;
         end
         OP_SUB: begin
            item_in.direct = a - b;
            item_in.pops   = 1'b1;
         end
         OP_MUL: begin
            item_in.direct = product;
            item_in.pops   = 1'b1;
         end
         OP_DIV, OP_MOD: begin
            item_in.pops = 1'b1;
            if (b == '0) begin
               item_in.div_zero = 1'b1;
            end else if (op_type'(req_ch.operation) == OP_DIV) begin
               item_in.sel    = SEL_QUOTIENT;
               item_in.negate = a[DataWidth-1] ^ b[DataWidth-1];
            end else begin
               item_in.sel    = SEL_REMAIN;
               item_in.negate = a[DataWidth-1];
            end
         end
         OP_NEG:  item_in.direct = ~b + 1'b1;
         OP_LT: begin
            item_in.direct = {{(DataWidth-1){1'b0}}, a_lt_b};
            item_in.pops   = 1'b1;
         end
         OP_LE: begin
            item_in.direct = {{(DataWidth-1){1'b0}}, !b_lt_a};
            item_in.pops   = 1'b1;
         end
         OP_GT: begin
            item_in.direct = {{(DataWidth-1){1'b0}}, b_lt_a};
            item_in.pops   = 1'b1;
         end
         OP_GE: begin
            item_in.direct = {{(DataWidth-1){1'b0}}, !a_lt_b};
            item_in.pops   = 1'b1;
         end
         OP_BOOL: item_in.direct = {{(DataWidth-1){1'b0}}, b != '0};
         OP_ABS:  item_in.direct = magnitude(b);
         OP_MAX: begin
            item_in.direct = a_lt_b ? b : a;
            item_in.pops   = 1'b1;
         end
         OP_MIN: begin
            item_in.direct = b_lt_a ? b : a;
            item_in.pops   = 1'b1;
         end
         OP_SIGN: begin
            if (b == '0) begin
               item_in.direct = '0;
            end else if (b[DataWidth-1]) begin
               item_in.direct = '1;
            end else begin
               item_in.direct = {{(DataWidth-1){1'b0}}, 1'b1};
            end
         end
         default: item_in.direct = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         item_ff <= item_in;
      end
   end

   assign out_item  = item_ff;
   assign out_valid = valid_ff;

endmodule

`default_nettype wire

@@ sv/sal_div_stage.sv @@
`default_nettype none

module sal_div_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sal_pkg::item_type    in_item,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   output sal_pkg::item_type         out_item,
   output logic                      out_valid,
   input  wire logic                 out_ready
);
   import sal_pkg::*;

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      item_in = in_item;
      for (int i = 0; i < DivBitsPerStage; i++) begin
         item_in = div_step(item_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_item  = item_ff;
   assign out_valid = valid_ff;

endmodule

`default_nettype wire

@@ sv/sal_back.sv @@
`default_nettype none

module sal_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sal_pkg::item_type    in_item,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   sal_rsp_if.source                 rsp_ch
);
   import sal_pkg::*;

   logic                  valid_ff;
   logic [DataWidth-1:0]  result_ff;
   logic                  pops_ff;
   logic                  div_zero_ff;
   logic [DataWidth-1:0]  result_in;
   logic [DataWidth-1:0]  raw;

   assign in_ready = !valid_ff || rsp_ch.ready;

   always_comb begin
      case (in_item.sel)
         SEL_QUOTIENT: raw = in_item.shift_q;
         SEL_REMAIN:   raw = in_item.remain;
         default:      raw = in_item.direct;
      endcase
      result_in = (in_item.negate && in_item.sel != SEL_DIRECT) ? (~raw + 1'b1) : raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         result_ff   <= result_in;
         pops_ff     <= in_item.pops;
         div_zero_ff <= in_item.div_zero;
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.result_value   = result_ff;
   assign rsp_ch.pops_one       = pops_ff;
   assign rsp_ch.divide_by_zero = div_zero_ff;

endmodule

`default_nettype wire

@@ tb/tb_stack_integer_alu.sv @@
`timescale 1ns / 100ps

// Self-checking testbench for the stack machine integer ALU.
//
// Every request item carries an operation code and the two top stack slots.
// When the block accepts an item, the testbench computes the new top of stack
// in its own model of the ALU and appends it to a queue. Each response item
// is checked field by field against the oldest entry of that queue.
//
// The request side and the response side each wait a random number of
// cycles before every item. Some stretches run with no waiting at all, so the
// pipeline is filled back to back and bubbles close up under output stalls. A
// watchdog ends the run when no item moves for too long.

module tb_stack_integer_alu;

   import sal_pkg::*;

   // Code 15 is outside the operation enum; the ALU returns zero and pops nothing.
   localparam logic [3:0] OP_UNDEF = 4'd15;

   localparam word_type WordMin = 32'sh8000_0000;
   localparam word_type WordMax = 32'sh7fff_ffff;
   localparam word_type MinusOne = 32'shffff_ffff;

   // The pipeline is 18 stages deep; the tail wait covers it with margin.
   localparam int TailCycles = 40;
   // Every quiet period in a correct run, the tail wait included, stays
   // far below this limit.
   localparam int WatchdogLimit = 2000;

   // Expected new top of stack and the two flags for one item.
   typedef struct packed {
      word_type value;
      logic     pops;
      logic     div_zero;
   } top_update_type;

   logic clock;
   logic reset;

   sal_req_if req_ch ();
   sal_rsp_if rsp_ch ();

   stack_integer_alu i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predicted results in the order their items were accepted.
   top_update_type pending_tops[$];

   int          sender_max_gap = 10;
   int          receiver_max_stall = 10;
   int          mismatch_count = 0;
   int          items_accepted = 0;
   int          zero_divisors = 0;
   bit [15:0]   codes_seen = '0;
   top_update_type oldest_top;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Model of the ALU. Division works on magnitudes and then fixes the sign,
   // which truncates toward zero and makes the minimum integer divided by
   // minus one wrap to the minimum integer with a zero remainder.
   function automatic top_update_type alu_eval(input logic [3:0] op,
                                               input word_type lhs,
                                               input word_type rhs);
      top_update_type upd;
      logic [31:0]    mag_lhs;
      logic [31:0]    mag_rhs;
      logic [31:0]    quot;
      logic [31:0]    remd;
      upd = '0;
      mag_lhs = lhs[31] ? (32'd0 - lhs) : lhs;
      mag_rhs = rhs[31] ? (32'd0 - rhs) : rhs;
      case (op)
         OP_ADD: begin
            upd.value = lhs + rhs;
            upd.pops = 1'b1;
         end
         OP_SUB: begin
            upd.value = lhs - rhs;
            upd.pops = 1'b1;
         end
         OP_MUL: begin
            upd.value = lhs * rhs;
            upd.pops = 1'b1;
         end
         OP_DIV, OP_MOD: begin
            upd.pops = 1'b1;
            if (rhs == 0) begin
               upd.div_zero = 1'b1;
            end else if (op == OP_DIV) begin
               quot = mag_lhs / mag_rhs;
               upd.value = (lhs[31] ^ rhs[31]) ? (32'd0 - quot) : quot;
            end else begin
               remd = mag_lhs % mag_rhs;
               upd.value = lhs[31] ? (32'd0 - remd) : remd;
            end
         end
         OP_NEG: upd.value = 32'd0 - rhs;
         OP_LT: begin
            upd.value = (lhs < rhs) ? 1 : 0;
            upd.pops = 1'b1;
         end
         OP_LE: begin
            upd.value = (lhs <= rhs) ? 1 : 0;
            upd.pops = 1'b1;
         end
         OP_GT: begin
            upd.value = (lhs > rhs) ? 1 : 0;
            upd.pops = 1'b1;
         end
         OP_GE: begin
            upd.value = (lhs >= rhs) ? 1 : 0;
            upd.pops = 1'b1;
         end
         OP_BOOL: upd.value = (rhs != 0) ? 1 : 0;
         OP_ABS:  upd.value = mag_rhs;
         OP_MAX: begin
            upd.value = (lhs < rhs) ? rhs : lhs;
            upd.pops = 1'b1;
         end
         OP_MIN: begin
            upd.value = (rhs < lhs) ? rhs : lhs;
            upd.pops = 1'b1;
         end
         OP_SIGN: upd.value = (rhs == 0) ? 0 : (rhs[31] ? MinusOne : 1);
         default: ;
      endcase
      return upd;
   endfunction

   // Operands lean toward the values where wrapping and sign handling matter,
   // but many are full 32-bit random patterns.
   function automatic word_type random_operand();
      word_type v;
      v = $urandom;
      case ($urandom_range(0, 11))
         0: v = 0;
         1: v = 1;
         2: v = MinusOne;
         3: v = WordMin;
         4: v = WordMax;
         5: v = $signed($urandom_range(0, 20)) - 10;
         6: v = v >>> $urandom_range(0, 31);
         default: ;
      endcase
      return v;
   endfunction

   // All fifteen operations, with the undefined code showing up now and then.
   function automatic logic [3:0] random_opcode();
      if ($urandom_range(0, 63) == 0) begin
         return OP_UNDEF;
      end
      return 4'($urandom_range(0, 14));
   endfunction

   // Drives one request item after a random gap and returns at the clock
   // edge where it is accepted. Valid gets at most one assignment per edge.
   task automatic push_operation(input logic [3:0] op, input word_type lhs,
                                 input word_type rhs);
      int gap;
      gap = $urandom_range(0, sender_max_gap);
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.operation    <= op;
      req_ch.second_value <= lhs;
      req_ch.top_value    <= rhs;
      do @(posedge clock); while (!req_ch.ready);
      pending_tops.push_back(alu_eval(op, lhs, rhs));
      items_accepted++;
      codes_seen[op] = 1'b1;
      if ((op == OP_DIV || op == OP_MOD) && rhs == 0) begin
         zero_divisors++;
      end
   endtask

   // Corners of every operation: wrapping add, subtract and multiply, the
   // zero divisor, the minimum integer divided by minus one, truncation with
   // mixed signs, negate and abs of the minimum integer, compares at the
   // extremes and on equal values, and the undefined operation code.
   task automatic test_directed_corners();
      push_operation(OP_ADD, WordMax, 1);
      push_operation(OP_SUB, WordMin, 1);
      push_operation(OP_MUL, WordMax, WordMax);
      push_operation(OP_MUL, WordMin, MinusOne);
      push_operation(OP_DIV, WordMin, MinusOne);
      push_operation(OP_MOD, WordMin, MinusOne);
      push_operation(OP_DIV, -7, 2);
      push_operation(OP_MOD, -7, 2);
      push_operation(OP_MOD, 7, -2);
      push_operation(OP_DIV, 5, 0);
      push_operation(OP_MOD, WordMin, 0);
      push_operation(OP_NEG, $urandom, WordMin);
      push_operation(OP_ABS, $urandom, WordMin);
      push_operation(OP_NEG, $urandom, 0);
      push_operation(OP_LT, WordMin, WordMax);
      push_operation(OP_LE, MinusOne, MinusOne);
      push_operation(OP_GT, WordMax, WordMin);
      push_operation(OP_GE, WordMin, WordMax);
      push_operation(OP_BOOL, $urandom, 0);
      push_operation(OP_BOOL, $urandom, WordMin);
      push_operation(OP_ABS, $urandom, MinusOne);
      push_operation(OP_MAX, WordMin, WordMax);
      push_operation(OP_MIN, WordMin, WordMax);
      push_operation(OP_SIGN, $urandom, WordMin);
      push_operation(OP_SIGN, $urandom, 0);
      push_operation(OP_SIGN, $urandom, WordMax);
      push_operation(OP_UNDEF, $urandom, $urandom);
   endtask

   // Random operations and operands with random idling on both sides.
   task automatic test_random_mix(input int count);
      repeat (count) begin
         push_operation(random_opcode(), random_operand(), random_operand());
      end
   endtask

   // The first half streams with no idling at all; in the second half only
   // the receiver stalls, so the pipeline fills up and has to hold its items.
   task automatic test_back_to_back(input int count);
      sender_max_gap = 0;
      receiver_max_stall = 0;
      repeat (count / 2) begin
         push_operation(random_opcode(), random_operand(), random_operand());
      end
      receiver_max_stall = 10;
      repeat (count - count / 2) begin
         push_operation(random_opcode(), random_operand(), random_operand());
      end
      sender_max_gap = 10;
   endtask

   // Divide and modulo only, with dividend and divisor magnitudes spread
   // over the whole range so that every divider stage retires nonzero bits.
   task automatic test_divider_spread(input int count);
      word_type   dividend;
      word_type   divisor;
      logic [3:0] op;
      repeat (count) begin
         op = $urandom_range(0, 1) ? OP_DIV : OP_MOD;
         dividend = word_type'($urandom) >>> $urandom_range(0, 31);
         divisor = word_type'($urandom) >>> $urandom_range(0, 31);
         if ($urandom_range(0, 15) == 0) begin
            divisor = 0;
         end
         push_operation(op, dividend, divisor);
      end
   endtask

   // Short bursts, each followed by a pause until every result is back, so
   // the block restarts from an empty pipeline several times.
   task automatic test_pause_until_drained(input int bursts);
      repeat (bursts) begin
         repeat ($urandom_range(1, 30)) begin
            push_operation(random_opcode(), random_operand(), random_operand());
         end
         @(negedge clock);
         req_ch.valid <= 1'b0;
         while (pending_tops.size() != 0) @(posedge clock);
      end
   endtask

   // Response side: wait a random number of cycles, then take one item.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = $urandom_range(0, receiver_max_stall);
         if (stall > 0) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_tops.size() == 0) begin
            $error("result with no item outstanding: result_value %0d",
                   rsp_ch.result_value);
            mismatch_count++;
         end else begin
            oldest_top = pending_tops.pop_front();
            if (rsp_ch.result_value !== oldest_top.value) begin
               $error("result_value: expected %0d, actual %0d",
                      oldest_top.value, rsp_ch.result_value);
               mismatch_count++;
            end
            if (rsp_ch.pops_one !== oldest_top.pops) begin
               $error("pops_one: expected %0b, actual %0b",
                      oldest_top.pops, rsp_ch.pops_one);
               mismatch_count++;
            end
            if (rsp_ch.divide_by_zero !== oldest_top.div_zero) begin
               $error("divide_by_zero: expected %0b, actual %0b",
                      oldest_top.div_zero, rsp_ch.divide_by_zero);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: counts clock cycles in which neither channel moves an item.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WatchdogLimit) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) ||
             (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("stack_integer_alu: mismatch");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.operation    = '0;
      req_ch.second_value = '0;
      req_ch.top_value    = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_random_mix(1100);
      test_back_to_back(250);
      test_divider_spread(200);
      test_pause_until_drained(5);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_tops.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);

      $display("Checked %0d items over %0d operation codes, %0d with a zero divisor,",
               items_accepted, $countones(codes_seen), zero_divisors);
      $display("under random idling, back-to-back streams and drained restarts.");
      if (mismatch_count == 0) begin
         $display("stack_integer_alu: match");
      end else begin
         $display("stack_integer_alu: mismatch");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/sal_pkg.sv
sv/sal_req_if.sv
sv/sal_rsp_if.sv
sv/sal_front.sv
sv/sal_div_stage.sv
sv/sal_back.sv
sv/stack_integer_alu.sv
tb/tb_stack_integer_alu.sv
